// ----- hw/rtl/cbcmac_pkg.sv -----
package cbcmac_pkg;

  localparam int unsigned BlockBytes = 16;
  localparam int unsigned AesRounds  = 10;

  // APB register byte addresses (64-bit registers, 8-byte stride)
  localparam logic [3:0] AddrKeyHigh = 4'h0;
  localparam logic [3:0] AddrKeyLow  = 4'h8;

  typedef logic [127:0] block_t;

  // Control handed from the sequencer to the round unit.
  typedef struct packed {
    logic       load;   // start: state := chain ^ key, round key := key
    logic       step;   // run one round
    logic [3:0] round;  // round being run, 1..10
  } rnd_ctrl_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r=8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] rnd);
    logic [7:0] r;
    case (rnd)
      4'd1: r = 8'h01;  4'd2: r = 8'h02;  4'd3: r = 8'h04;  4'd4: r = 8'h08;
      4'd5: r = 8'h10;  4'd6: r = 8'h20;  4'd7: r = 8'h40;  4'd8: r = 8'h80;
      4'd9: r = 8'h1b;  4'd10: r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a block (i = 0 first) sits at bits [127-8i -: 8].
  function automatic logic [7:0] get_byte(input block_t b, input int unsigned i);
    return b[127 - 8*i -: 8];
  endfunction

endpackage

// ----- hw/rtl/cbc_mac_aes128_tagger.sv -----
// Channel | dir | payload
// s_axis  | in  | tdata[7:0] = data_byte, tlast = last_byte
// m_axis  | out | tdata[127:0] = {tag_high, tag_low} (tag_low low bits)
// apb     | in  | 0x0 key_high, 0x8 key_low (64-bit data)
//
// A byte that does not close a block is taken without dropping s_axis_tready.
// A byte that closes a block or carries tlast holds s_axis_tready low for
// the load (chain ^ key), the 10 rounds in the shared unit and the take of
// the result; the next byte goes in only after that.
// The tag sits in an output register while new bytes keep coming; a second
// tag waits in the take cycle (input stalled) until the first one leaves.
// Reset clears the chain, the byte count and the keys; no clearing pass.
module cbc_mac_aes128_tagger (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // [63:0] tag_low, [127:64] tag_high
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  typedef enum logic [1:0] {StIdle, StLoad, StRound, StFin} state_e;

  state_e                state_q;
  logic [63:0]           key_high_q, key_low_q;
  cbcmac_pkg::block_t    chain_q;
  logic [3:0]            pos_q;
  logic [3:0]            round_q;
  logic                  last_q;
  logic [127:0]          tag_q;
  logic                  m_valid_q;
  logic                  tag_take;
  logic                  in_fire;
  cbcmac_pkg::block_t    chain_x;
  cbcmac_pkg::block_t    aes_state;
  cbcmac_pkg::rnd_ctrl_t rctl;

  assign pready = 1'b1;
  assign prdata = (paddr == cbcmac_pkg::AddrKeyLow) ? key_low_q : key_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        cbcmac_pkg::AddrKeyHigh: key_high_q <= pwdata;
        cbcmac_pkg::AddrKeyLow:  key_low_q  <= pwdata;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = tag_q;

  // final result of a message may be taken once the output register frees up
  assign tag_take = (state_q == StFin) && last_q && (!m_valid_q || m_axis_tready);

  always_comb begin
    chain_x = chain_q;
    chain_x[127 - 8*pos_q -: 8] = chain_q[127 - 8*pos_q -: 8] ^ s_axis_tdata;
  end

  assign rctl.load  = (state_q == StLoad);
  assign rctl.step  = (state_q == StRound);
  assign rctl.round = round_q;

  cbcmac_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (rctl),
    .data_i  (chain_q),
    .key_i   ({key_high_q, key_low_q}),
    .state_o (aes_state)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      chain_q   <= '0;
      pos_q     <= '0;
      round_q   <= '0;
      last_q    <= 1'b0;
      tag_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= tag_take || (m_valid_q && !m_axis_tready);
      case (state_q)
        StIdle: begin
          if (in_fire) begin
            chain_q <= chain_x;
            pos_q   <= pos_q + 4'd1;
            last_q  <= s_axis_tlast;
            if (s_axis_tlast || pos_q == 4'd15) begin
              state_q <= StLoad;
            end
          end
        end
        StLoad: begin
          round_q <= 4'd1;
          state_q <= StRound;
        end
        StRound: begin
          round_q <= round_q + 4'd1;
          if (round_q == 4'(cbcmac_pkg::AesRounds)) begin
            state_q <= StFin;
          end
        end
        // round unit output now holds the encrypted block
        StFin: begin
          if (!last_q) begin
            chain_q <= aes_state;
            state_q <= StIdle;
          end else if (tag_take) begin
            tag_q   <= aes_state;
            chain_q <= '0;
            pos_q   <= '0;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata));

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> !s_axis_tready);

  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRound |-> (round_q >= 4'd1 && round_q <= 4'(cbcmac_pkg::AesRounds)));

  a_round_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRound && round_q == 4'(cbcmac_pkg::AesRounds) |=> state_q == StFin);

endmodule

// ----- hw/rtl/cbcmac_round.sv -----
// One AES-128 round per step, key schedule computed on the fly.
module cbcmac_round (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cbcmac_pkg::rnd_ctrl_t  ctrl_i,
  input  cbcmac_pkg::block_t     data_i,
  input  cbcmac_pkg::block_t     key_i,
  output cbcmac_pkg::block_t     state_o
);

  cbcmac_pkg::block_t state_q, state_d;
  cbcmac_pkg::block_t rk_q, rk_d;
  cbcmac_pkg::block_t sr;
  cbcmac_pkg::block_t mc;
  logic [31:0]        w3, tw;
  logic [7:0]         a0, a1, a2, a3, al;

  always_comb begin
    // next round key
    w3 = rk_q[31:0];
    tw = {cbcmac_pkg::sbox(w3[23:16]) ^ cbcmac_pkg::rcon(ctrl_i.round),
          cbcmac_pkg::sbox(w3[15:8]), cbcmac_pkg::sbox(w3[7:0]),
          cbcmac_pkg::sbox(w3[31:24])};
    rk_d[127:96] = rk_q[127:96] ^ tw;
    rk_d[95:64]  = rk_q[95:64]  ^ rk_d[127:96];
    rk_d[63:32]  = rk_q[63:32]  ^ rk_d[95:64];
    rk_d[31:0]   = rk_q[31:0]   ^ rk_d[63:32];
    // SubBytes + ShiftRows
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        sr[127 - 8*(i + 4*c) -: 8] =
          cbcmac_pkg::sbox(cbcmac_pkg::get_byte(state_q, i + 4*((c + i) % 4)));
      end
    end
    mc = sr;
    if (ctrl_i.round != 4'(cbcmac_pkg::AesRounds)) begin
      for (int c = 0; c < 4; c++) begin
        a0 = cbcmac_pkg::get_byte(sr, 4*c);
        a1 = cbcmac_pkg::get_byte(sr, 4*c + 1);
        a2 = cbcmac_pkg::get_byte(sr, 4*c + 2);
        a3 = cbcmac_pkg::get_byte(sr, 4*c + 3);
        al = a0 ^ a1 ^ a2 ^ a3;
        mc[127 - 32*c -: 32] = {a0 ^ al ^ cbcmac_pkg::xtime(a0 ^ a1),
                                a1 ^ al ^ cbcmac_pkg::xtime(a1 ^ a2),
                                a2 ^ al ^ cbcmac_pkg::xtime(a2 ^ a3),
                                a3 ^ al ^ cbcmac_pkg::xtime(a3 ^ a0)};
      end
    end else begin
      a0 = '0; a1 = '0; a2 = '0; a3 = '0; al = '0;
    end
    state_d = state_q;
    if (ctrl_i.load) begin
      state_d = data_i ^ key_i;
    end else if (ctrl_i.step) begin
      state_d = mc ^ rk_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      rk_q    <= '0;
    end else begin
      state_q <= state_d;
      if (ctrl_i.load) begin
        rk_q <= key_i;
      end else if (ctrl_i.step) begin
        rk_q <= rk_d;
      end
    end
  end

  assign state_o = state_q;

endmodule
